FILE: src/rrc_pkg.sv
package rrc_pkg;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ADD  = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic atom_load;
      logic accumulate;
      logic clear;
      logic div_load;
      logic div_step;
      logic out_load;
      logic out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic key_mismatch;
      logic run_close;
   } dp_status_type;

endpackage

FILE: src/rrc_if.sv
interface rrc_atom_if #(
   parameter int KEY_WIDTH   = 32,
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic        [KEY_WIDTH-1:0]   residue_key;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   logic signed [COORD_WIDTH-1:0] coord_z;
   logic                          last_atom;

   modport source (output valid, residue_key, coord_x, coord_y, coord_z, last_atom,
                   input ready);
   modport sink   (input valid, residue_key, coord_x, coord_y, coord_z, last_atom,
                   output ready);
endinterface

interface rrc_group_if #(
   parameter int KEY_WIDTH   = 32,
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic        [KEY_WIDTH-1:0]   group_key;
   logic signed [COORD_WIDTH-1:0] centroid_x;
   logic signed [COORD_WIDTH-1:0] centroid_y;
   logic signed [COORD_WIDTH-1:0] centroid_z;
   logic        [COUNT_WIDTH-1:0] group_count;
   logic                          last_group;

   modport source (output valid, group_key, centroid_x, centroid_y, centroid_z,
                   group_count, last_group, input ready);
   modport sink   (input valid, group_key, centroid_x, centroid_y, centroid_z,
                   group_count, last_group, output ready);
endinterface

interface rrc_csr_if;
   logic valid;
   logic ready;
   logic summarize_enable;

   modport source (output valid, summarize_enable, input ready);
   modport sink   (input valid, summarize_enable, output ready);
endinterface

FILE: src/residue_run_centroid.sv
// channel     port        dir  contents
// atoms       req_atom    in   residue_key, coord_x, coord_y, coord_z, last_atom
// groups      rsp_group   out  group_key, centroid_x/y/z, group_count, last_group
// control     csr_cfg     in   summarize_enable
//
// an atom that does not close a run is accepted, then accumulated
// closing a run then loads the three restoring dividers, steps them (one quotient bit
// per cycle) and registers the group word, which may then wait on rsp_group
// one atom is handled at a time; req_atom is not ready while a group word waits
// reset is synchronous and returns to an empty run with summarizing enabled
module residue_run_centroid #(
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16,
   parameter int KEY_WIDTH   = 32
) (
   input logic          clock,
   input logic          reset,
   rrc_atom_if.sink     req_atom,
   rrc_group_if.source  rsp_group,
   rrc_csr_if.sink      csr_cfg
);

   rrc_pkg::dp_cmd_type    cmd;
   rrc_pkg::dp_status_type status;

   rrc_ctrl #(
      .SUM_WIDTH (COORD_WIDTH + COUNT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_atom.valid),
      .req_ready  (req_atom.ready),
      .rsp_valid  (rsp_group.valid),
      .rsp_ready  (rsp_group.ready),
      .csr_valid  (csr_cfg.valid),
      .csr_ready  (csr_cfg.ready),
      .csr_enable (csr_cfg.summarize_enable),
      .status     (status),
      .cmd        (cmd)
   );

   rrc_dp #(
      .KEY_WIDTH   (KEY_WIDTH),
      .COORD_WIDTH (COORD_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .residue_key (req_atom.residue_key),
      .coord_x     (req_atom.coord_x),
      .coord_y     (req_atom.coord_y),
      .coord_z     (req_atom.coord_z),
      .last_atom   (req_atom.last_atom),
      .group_key   (rsp_group.group_key),
      .centroid_x  (rsp_group.centroid_x),
      .centroid_y  (rsp_group.centroid_y),
      .centroid_z  (rsp_group.centroid_z),
      .group_count (rsp_group.group_count),
      .last_group  (rsp_group.last_group)
   );

endmodule

FILE: src/rrc_div.sv
module rrc_div #(
   parameter int DIVIDEND_WIDTH = 48,
   parameter int DIVISOR_WIDTH  = 16,
   parameter int QUOT_WIDTH     = 32
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             step,
   input  logic signed [DIVIDEND_WIDTH-1:0] dividend,
   input  logic        [DIVISOR_WIDTH-1:0]  divisor,
   output logic signed [QUOT_WIDTH-1:0]     quotient
);

   logic                      neg_ff, neg_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH:0]    rem_sh;
   logic [DIVISOR_WIDTH+1:0]  diff;
   logic                      fits;
   logic [DIVIDEND_WIDTH-1:0] mag;

   // restoring division on the magnitude, one quotient bit per step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      diff   = {1'b0, rem_sh} - {2'b00, divisor};
      fits   = ~diff[DIVISOR_WIDTH+1];
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (load) begin
         neg_in = dividend[DIVIDEND_WIDTH-1];
         quo_in = dividend[DIVIDEND_WIDTH-1] ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
      end else if (step) begin
         quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : rem_sh[DIVISOR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign mag      = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient = mag[QUOT_WIDTH-1:0];

endmodule

FILE: src/rrc_dp.sv
module rrc_dp #(
   parameter int KEY_WIDTH   = 32,
   parameter int COORD_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrc_pkg::dp_cmd_type           cmd,
   output rrc_pkg::dp_status_type        status,
   input  logic        [KEY_WIDTH-1:0]   residue_key,
   input  logic signed [COORD_WIDTH-1:0] coord_x,
   input  logic signed [COORD_WIDTH-1:0] coord_y,
   input  logic signed [COORD_WIDTH-1:0] coord_z,
   input  logic                          last_atom,
   output logic        [KEY_WIDTH-1:0]   group_key,
   output logic signed [COORD_WIDTH-1:0] centroid_x,
   output logic signed [COORD_WIDTH-1:0] centroid_y,
   output logic signed [COORD_WIDTH-1:0] centroid_z,
   output logic        [COUNT_WIDTH-1:0] group_count,
   output logic                          last_group
);

   localparam int SUM_WIDTH = COORD_WIDTH + COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] NEAR_FULL = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

   logic        [KEY_WIDTH-1:0]   atom_key_ff, atom_key_in;
   logic signed [COORD_WIDTH-1:0] atom_coord_ff [3];
   logic signed [COORD_WIDTH-1:0] atom_coord_in [3];
   logic                          atom_last_ff, atom_last_in;

   logic        [KEY_WIDTH-1:0]   run_key_ff, run_key_in;
   logic        [COUNT_WIDTH-1:0] run_count_ff, run_count_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff [3];
   logic signed [SUM_WIDTH-1:0]   sum_in [3];

   logic signed [COORD_WIDTH-1:0] quot [3];

   logic        [KEY_WIDTH-1:0]   key_out_ff, key_out_in;
   logic signed [COORD_WIDTH-1:0] cent_ff [3];
   logic signed [COORD_WIDTH-1:0] cent_in [3];
   logic        [COUNT_WIDTH-1:0] count_out_ff, count_out_in;
   logic                          last_out_ff, last_out_in;

   assign status.key_mismatch = (run_count_ff != '0) && (residue_key != run_key_ff);
   // the atom being added brings the run to the largest count, or is the last atom
   assign status.run_close    = (run_count_ff == NEAR_FULL) || atom_last_ff;

   always_comb begin
      atom_key_in  = atom_key_ff;
      atom_last_in = atom_last_ff;
      for (int i = 0; i < 3; i++) atom_coord_in[i] = atom_coord_ff[i];
      if (cmd.atom_load) begin
         atom_key_in      = residue_key;
         atom_coord_in[0] = coord_x;
         atom_coord_in[1] = coord_y;
         atom_coord_in[2] = coord_z;
         atom_last_in     = last_atom;
      end
   end

   always_comb begin
      run_key_in   = run_key_ff;
      run_count_in = run_count_ff;
      for (int i = 0; i < 3; i++) sum_in[i] = sum_ff[i];
      if (cmd.clear) begin
         run_key_in   = '0;
         run_count_in = '0;
         for (int i = 0; i < 3; i++) sum_in[i] = '0;
      end else if (cmd.accumulate) begin
         if (run_count_ff == '0) run_key_in = atom_key_ff;
         run_count_in = run_count_ff + 1'b1;
         for (int i = 0; i < 3; i++) begin
            sum_in[i] = sum_ff[i]
                      + {{COUNT_WIDTH{atom_coord_ff[i][COORD_WIDTH-1]}}, atom_coord_ff[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_key_ff   <= '0;
         run_count_ff <= '0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end else begin
         run_key_ff   <= run_key_in;
         run_count_ff <= run_count_in;
         for (int i = 0; i < 3; i++) sum_ff[i] <= sum_in[i];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rrc_div #(
         .DIVIDEND_WIDTH (SUM_WIDTH),
         .DIVISOR_WIDTH  (COUNT_WIDTH),
         .QUOT_WIDTH     (COORD_WIDTH)
      ) u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_step),
         .dividend (sum_ff[g]),
         .divisor  (run_count_ff),
         .quotient (quot[g])
      );
   end

   always_comb begin
      key_out_in   = key_out_ff;
      count_out_in = count_out_ff;
      last_out_in  = last_out_ff;
      for (int i = 0; i < 3; i++) cent_in[i] = cent_ff[i];
      if (cmd.out_load) begin
         key_out_in   = run_key_ff;
         count_out_in = run_count_ff;
         last_out_in  = cmd.out_last & atom_last_ff;
         for (int i = 0; i < 3; i++) cent_in[i] = quot[i];
      end
   end

   always_ff @(posedge clock) begin
      atom_key_ff  <= atom_key_in;
      atom_last_ff <= atom_last_in;
      key_out_ff   <= key_out_in;
      count_out_ff <= count_out_in;
      last_out_ff  <= last_out_in;
      for (int i = 0; i < 3; i++) begin
         atom_coord_ff[i] <= atom_coord_in[i];
         cent_ff[i]       <= cent_in[i];
      end
   end

   assign group_key   = key_out_ff;
   assign centroid_x  = cent_ff[0];
   assign centroid_y  = cent_ff[1];
   assign centroid_z  = cent_ff[2];
   assign group_count = count_out_ff;
   assign last_group  = last_out_ff;

endmodule

FILE: src/rrc_ctrl.sv
module rrc_ctrl #(
   parameter int SUM_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_enable,
   input  rrc_pkg::dp_status_type status,
   output rrc_pkg::dp_cmd_type    cmd
);

   localparam int STEP_WIDTH = $clog2(SUM_WIDTH + 1);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(SUM_WIDTH - 1);

   rrc_pkg::state_type     state_ff, state_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   enable_ff, enable_in;
   logic                   second_ff, second_in;

   assign csr_ready = 1'b1;
   assign enable_in = csr_valid ? csr_enable : enable_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      second_in = second_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         rrc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!enable_ff) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.atom_load = 1'b1;
                  // key change closes the open run before the atom is added
                  if (status.key_mismatch) begin
                     second_in = 1'b0;
                     state_in  = rrc_pkg::ST_LOAD;
                  end else begin
                     state_in  = rrc_pkg::ST_ADD;
                  end
               end
            end
         end
         rrc_pkg::ST_ADD: begin
            cmd.accumulate = 1'b1;
            if (status.run_close) begin
               second_in = 1'b1;
               state_in  = rrc_pkg::ST_LOAD;
            end else begin
               state_in  = rrc_pkg::ST_IDLE;
            end
         end
         rrc_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = rrc_pkg::ST_DIV;
         end
         rrc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = rrc_pkg::ST_FIN;
         end
         rrc_pkg::ST_FIN: begin
            cmd.out_load = 1'b1;
            cmd.out_last = second_ff;
            state_in     = rrc_pkg::ST_OUT;
         end
         rrc_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = second_ff ? rrc_pkg::ST_IDLE : rrc_pkg::ST_ADD;
            end
         end
         default: begin
            state_in = rrc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rrc_pkg::ST_IDLE;
         enable_ff <= 1'b1;
         second_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         enable_ff <= enable_in;
         second_ff <= second_in;
         step_ff   <= step_in;
      end
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int KEY_W   = 32;
   localparam int COORD_W = 32;
   localparam int COUNT_W = 16;
   localparam int RUN_MAX = (1 << COUNT_W) - 1;

   // divider latency plus margin
   localparam int SETTLE_CYCLES = 3 + COORD_W + COUNT_W + 30;
   localparam int END_CYCLES    = 100;
   localparam int STALL_LIMIT   = 20000;

   typedef enum int {PACE_RSP_SLOW, PACE_REQ_SLOW, PACE_NONE} pace_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } atom_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [COUNT_W-1:0]        count;
      logic                      last;
   } group_type;

   logic clock;
   logic reset;

   rrc_atom_if #(.KEY_WIDTH(KEY_W), .COORD_WIDTH(COORD_W)) atom_ch ();
   rrc_group_if #(.KEY_WIDTH(KEY_W), .COORD_WIDTH(COORD_W), .COUNT_WIDTH(COUNT_W)) group_ch ();
   rrc_csr_if cfg_ch ();

   residue_run_centroid #(
      .COORD_WIDTH(COORD_W),
      .COUNT_WIDTH(COUNT_W),
      .KEY_WIDTH(KEY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_atom(atom_ch),
      .rsp_group(group_ch),
      .csr_cfg(cfg_ch)
   );

   // run accumulator mirror
   logic              enable_q;
   logic [KEY_W-1:0]  run_key_q;
   longint            sum_x_q, sum_y_q, sum_z_q;
   int                run_len_q;
   group_type         expected_groups[$];

   pace_type pace;
   int       rsp_hold_len;
   int       fail_count;
   int       quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int req_idle_pct();
      case (pace)
         PACE_RSP_SLOW: return 33;
         PACE_REQ_SLOW: return 86;
         default:       return 0;
      endcase
   endfunction

   function automatic int rsp_idle_pct();
      case (pace)
         PACE_RSP_SLOW: return 86;
         PACE_REQ_SLOW: return 33;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] centroid(input longint s, input longint n);
      longint q;
      q = s / n;   // signed divide truncates toward zero
      return q[COORD_W-1:0];
   endfunction

   task automatic clear_run();
      run_key_q = '0;
      sum_x_q   = 0;
      sum_y_q   = 0;
      sum_z_q   = 0;
      run_len_q = 0;
   endtask

   task automatic emit_group(input logic last);
      group_type g;
      g.key   = run_key_q;
      g.cx    = centroid(sum_x_q, longint'(run_len_q));
      g.cy    = centroid(sum_y_q, longint'(run_len_q));
      g.cz    = centroid(sum_z_q, longint'(run_len_q));
      g.count = run_len_q[COUNT_W-1:0];
      g.last  = last;
      expected_groups.push_back(g);
      clear_run();
   endtask

   task automatic account_atom(input atom_type a);
      if (!enable_q) begin
         clear_run();
         return;
      end
      if (run_len_q != 0 && a.key != run_key_q)
         emit_group(1'b0);
      if (run_len_q == 0)
         run_key_q = a.key;
      sum_x_q += longint'($signed(a.x));
      sum_y_q += longint'($signed(a.y));
      sum_z_q += longint'($signed(a.z));
      run_len_q++;
      if (run_len_q >= RUN_MAX || a.last)
         emit_group(a.last);
   endtask

   function automatic atom_type mk(input logic [KEY_W-1:0] key, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                   input logic last);
      atom_type a;
      a.key  = key;
      a.x    = x;
      a.y    = y;
      a.z    = z;
      a.last = last;
      return a;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(6) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_atom(input atom_type a);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < req_idle_pct())
         gap++;
      if (gap > 0) begin
         @(negedge clock);
         atom_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      atom_ch.valid       <= 1'b1;
      atom_ch.residue_key <= a.key;
      atom_ch.coord_x     <= a.x;
      atom_ch.coord_y     <= a.y;
      atom_ch.coord_z     <= a.z;
      atom_ch.last_atom   <= a.last;
      do @(posedge clock); while (!atom_ch.ready);
      account_atom(a);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      atom_ch.valid <= 1'b0;
      while (expected_groups.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_enable(input logic en);
      wait_drained();
      // the last atom may still be accumulating after its word left the queue
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      cfg_ch.valid            <= 1'b1;
      cfg_ch.summarize_enable <= en;
      do @(posedge clock); while (!cfg_ch.ready);
      enable_q = en;
      @(negedge clock);
      cfg_ch.valid <= 1'b0;
   endtask

   task automatic test_directed();
      // single atom run, key equal to the reset key
      send_atom(mk(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1));
      // two atoms at the coordinate extremes
      send_atom(mk(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, -1, 1'b0));
      send_atom(mk(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1, 1'b1));
      // truncation toward zero on both signs
      send_atom(mk(32'h0000_00a1, -3, 5, -1, 1'b0));
      send_atom(mk(32'h0000_00a1, 0, 0, 0, 1'b0));
      send_atom(mk(32'h0000_00a1, 0, 0, 0, 1'b0));
      // key change and last on one atom: two words
      send_atom(mk(32'h0000_00b2, 1, 1, 1, 1'b1));
      // adjacent residues sharing a key merge into one run
      for (int i = 0; i < 4; i++)
         send_atom(mk(32'h5555_5555, i * 7 - 9, -i, i, 1'b0));
      send_atom(mk(32'h5555_5555, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
      // alternating keys, single atom runs
      send_atom(mk(32'haaaa_aaaa, 10, -10, 3, 1'b0));
      send_atom(mk(32'h5555_5555, -7, 7, -3, 1'b0));
      send_atom(mk(32'haaaa_aaaa, 32'h8000_0000, 0, 32'h7fff_ffff, 1'b0));
      send_atom(mk(32'h5555_5555, 1, 2, 3, 1'b0));
      send_atom(mk(32'haaaa_aaaa, -1, -1, -1, 1'b1));
      // run left open, closed by a key change, then a fresh run
      send_atom(mk(32'h1357_9bdf, 100, 200, 300, 1'b0));
      send_atom(mk(32'h1357_9bdf, -100, -201, 299, 1'b0));
      send_atom(mk(32'h2468_ace0, 5, 5, 5, 1'b0));
      send_atom(mk(32'h2468_ace0, 6, 6, 6, 1'b1));
      wait_drained();
   endtask

   task automatic test_disable();
      for (int i = 0; i < 3; i++)
         send_atom(mk(32'h0000_1234, rand_coord(), rand_coord(), rand_coord(), 1'b0));
      write_enable(1'b0);
      // all ignored, and the open run is dropped
      send_atom(mk(32'h0000_1234, 9, 9, 9, 1'b0));
      send_atom(mk(32'h0000_9999, 9, 9, 9, 1'b1));
      send_atom(mk(32'h0000_1234, 9, 9, 9, 1'b1));
      send_atom(mk(32'h0000_1234, 9, 9, 9, 1'b0));
      write_enable(1'b1);
      send_atom(mk(32'h0000_1234, 4, -4, 8, 1'b0));
      send_atom(mk(32'h0000_1234, 5, -5, 9, 1'b1));
      send_atom(mk(32'h0000_0777, 1, 2, 3, 1'b0));
      send_atom(mk(32'h0000_0777, 4, 5, 6, 1'b0));
      write_enable(1'b0);
      send_atom(mk(32'h0000_0888, 1, 1, 1, 1'b0));
      write_enable(1'b1);
      send_atom(mk(32'h0000_0777, -8, 16, 32'h8000_0000, 1'b1));
      wait_drained();
   endtask

   task automatic test_random(input int n_atoms);
      logic [KEY_W-1:0] key_pool[4];
      logic [KEY_W-1:0] key;
      int sent, n_runs, len;
      logic last;
      for (int i = 0; i < 4; i++)
         key_pool[i] = $urandom;
      key  = key_pool[0];
      sent = 0;
      while (sent < n_atoms) begin
         if ($urandom_range(9) == 0) begin
            // stray atom with random flag
            send_atom(mk($urandom, rand_coord(), rand_coord(), rand_coord(),
                         1'($urandom_range(1))));
            sent++;
         end else begin
            n_runs = $urandom_range(1, 6);
            for (int r = 0; r < n_runs; r++) begin
               case ($urandom_range(9))
                  0, 1:    key = key;   // neighboring residue, same key
                  2:       key = $urandom;
                  3:       key = $urandom_range(1) ? '1 : '0;
                  default: key = key_pool[2'($urandom_range(3))];
               endcase
               len = ($urandom_range(4) == 0) ? $urandom_range(6, 30) : $urandom_range(1, 5);
               for (int i = 0; i < len; i++) begin
                  last = (r == n_runs - 1 && i == len - 1 && $urandom_range(9) != 0);
                  if ($urandom_range(39) == 0)
                     last = 1'b1;
                  send_atom(mk(key, rand_coord(), rand_coord(), rand_coord(), last));
                  sent++;
               end
            end
         end
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      rsp_hold_len = 400;
      // every atom closes the previous run, so words pile up
      for (int i = 0; i < 24; i++)
         send_atom(mk(32'h100 + i, rand_coord(), rand_coord(), rand_coord(), i % 8 == 7));
      wait_drained();
      for (int i = 0; i < 10; i++)
         send_atom(mk(32'h200 + i / 3, rand_coord(), rand_coord(), rand_coord(), i == 9));
      wait_drained();
   endtask

   task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_groups
      group_type want;
      if (!reset && group_ch.valid && group_ch.ready) begin
         if (expected_groups.size() == 0) begin
            $error("group word with no run pending: key %0h", group_ch.group_key);
            fail_count++;
         end else begin
            want = expected_groups.pop_front();
            compare("group_key", want.key, group_ch.group_key);
            compare("centroid_x", want.cx, group_ch.centroid_x);
            compare("centroid_y", want.cy, group_ch.centroid_y);
            compare("centroid_z", want.cz, group_ch.centroid_z);
            compare("group_count", want.count, group_ch.group_count);
            compare("last_group", want.last, group_ch.last_group);
         end
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      group_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            group_ch.ready <= 1'b0;
            repeat (rsp_hold_len - 1) @(negedge clock);
            rsp_hold_len = 0;
         end else begin
            group_ch.ready <= ($urandom_range(99) >= rsp_idle_pct());
         end
      end
   end

   always @(posedge clock) begin
      if ((atom_ch.valid && atom_ch.ready) || (group_ch.valid && group_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset                   = 1'b1;
      atom_ch.valid           = 1'b0;
      atom_ch.residue_key     = '0;
      atom_ch.coord_x         = '0;
      atom_ch.coord_y         = '0;
      atom_ch.coord_z         = '0;
      atom_ch.last_atom       = 1'b0;
      cfg_ch.valid            = 1'b0;
      cfg_ch.summarize_enable = 1'b1;
      rsp_hold_len            = 0;
      fail_count              = 0;
      quiet_cycles            = 0;
      pace                    = PACE_RSP_SLOW;
      enable_q                = 1'b1;
      clear_run();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_disable();
      test_random(425);
      pace = PACE_REQ_SLOW;
      test_random(425);
      pace = PACE_NONE;
      test_random(425);
      test_backpressure();

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_groups.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
src/rrc_pkg.sv
src/rrc_if.sv
src/rrc_div.sv
src/rrc_dp.sv
src/rrc_ctrl.sv
src/residue_run_centroid.sv
bench/tb.sv
